[rtl/fixed_block_pool_allocator_defines.svh]
// Assertion macros for the block pool allocator checker.
`ifndef FIXED_BLOCK_POOL_ALLOCATOR_DEFINES_SVH
`define FIXED_BLOCK_POOL_ALLOCATOR_DEFINES_SVH

// Same-cycle implication.
`define FBPA_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define FBPA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

// Delayed implication.
`define FBPA_ASSERT_TWO(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> ##2 (cons)) \
        else $error(msg);

`endif

[rtl/fbpa_pkg.sv]
// Types and constants shared by the block pool allocator.
package fbpa_pkg;

    localparam int MAX_BLOCKS_DEF  = 4096;
    localparam int CACHE_DEPTH_DEF = 128;

    localparam int INDEX_W    = 12;
    localparam int OFFSET_W   = 28;
    localparam int BLOCKS_W   = 13;
    localparam int BYTES_W    = 17;
    localparam int CFG_DATA_W = 17;

    localparam int BLOCKS_RST = 4096;
    localparam logic [BYTES_W-1:0] MIN_BLOCK_BYTES = 17'd64;
    localparam logic [BYTES_W-1:0] MAX_BLOCK_BYTES = 17'd65536;

    typedef enum logic {
        OP_ALLOC,
        OP_FREE
    } t_op;

    typedef enum logic [1:0] {
        STATUS_OK        = 2'd0,
        STATUS_EMPTY     = 2'd1,
        STATUS_BAD_INDEX = 2'd2
    } t_status;

    typedef enum logic {
        CFG_BLOCKS_IN_USE,
        CFG_BLOCK_BYTES
    } t_cfg_index;

    typedef enum logic {
        ST_IDLE,
        ST_LOOKUP
    } t_state;

    typedef enum logic [2:0] {
        SRC_CACHE,
        SRC_LIST,
        SRC_FRESH,
        SRC_NONE,
        SRC_PUSH_CACHE,
        SRC_PUSH_LIST,
        SRC_BAD
    } t_src;

    typedef struct packed {
        t_op                operation;
        logic [INDEX_W-1:0] block_index;
    } t_item;

    typedef struct packed {
        t_status             status;
        logic [INDEX_W-1:0]  granted_index;
        logic [OFFSET_W-1:0] byte_offset;
        logic                from_cache;
    } t_result;

endpackage

[rtl/fbpa_ram.sv]
// Simple dual-port synchronous RAM, one write and one registered read port.
module fbpa_ram #(
    parameter int WIDTH = 12,
    parameter int DEPTH = 128,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/fbpa_ctrl.sv]
// Allocator control: source selection, pointer updates and result formation.
module fbpa_ctrl #(
    parameter int MAX_BLOCKS  = fbpa_pkg::MAX_BLOCKS_DEF,
    parameter int CACHE_DEPTH = fbpa_pkg::CACHE_DEPTH_DEF,
    localparam int HW  = $clog2(MAX_BLOCKS + 1),
    localparam int IW  = $clog2(MAX_BLOCKS),
    localparam int CAW = (CACHE_DEPTH > 1) ? $clog2(CACHE_DEPTH) : 1
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    start,
    output logic                    busy,
    input  fbpa_pkg::t_item         i_item,
    input  logic [HW-1:0]           i_pool_n,
    input  logic [fbpa_pkg::BYTES_W-1:0] i_bsize,
    output logic                    o_done,
    output fbpa_pkg::t_result       o_result,
    output logic                    o_cache_we,
    output logic [CAW-1:0]          o_cache_waddr,
    output logic [IW-1:0]           o_cache_wdata,
    output logic                    o_cache_re,
    output logic [CAW-1:0]          o_cache_raddr,
    input  logic [IW-1:0]           i_cache_rdata,
    output logic                    o_link_we,
    output logic [IW-1:0]           o_link_waddr,
    output logic [HW-1:0]           o_link_wdata,
    output logic                    o_link_re,
    output logic [IW-1:0]           o_link_raddr,
    input  logic [HW-1:0]           i_link_rdata
);

    import fbpa_pkg::*;

    localparam int CCW = $clog2(CACHE_DEPTH + 1);
    localparam int PW  = IW + BYTES_W;

    t_state r_state, n_state;
    t_src   r_src, n_src, src;
    logic [IW-1:0]  r_grant, n_grant;
    logic [HW-1:0]  r_head, n_head;
    logic [HW-1:0]  r_fresh, n_fresh;
    logic [CCW-1:0] r_count, n_count;
    logic           r_done;
    t_result        r_result, n_result;

    logic accept, lookup;
    logic idx_bad, cache_has, cache_full, list_has, fresh_has;
    logic [IW+INDEX_W-1:0] idx_ext;
    logic [IW-1:0]  idx_i;
    logic [CCW-1:0] cnt_m1;
    logic [IW-1:0]  lk_grant;
    logic [PW-1:0]  prod;

    // FSM next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE:   if (start) n_state = ST_LOOKUP;
            ST_LOOKUP: n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    // FSM outputs
    always_comb begin
        busy   = 1'b0;
        lookup = 1'b0;
        case (r_state)
            ST_IDLE:   busy = 1'b0;
            ST_LOOKUP: begin
                busy   = 1'b1;
                lookup = 1'b1;
            end
            default:   busy = 1'b0;
        endcase
    end

    assign accept = start && !busy;

    assign idx_ext    = {{IW{1'b0}}, i_item.block_index};
    assign idx_i      = idx_ext[IW-1:0];
    assign idx_bad    = ({{HW{1'b0}}, i_item.block_index}
                         >= {{INDEX_W{1'b0}}, i_pool_n});
    assign cache_has  = (r_count != '0);
    assign cache_full = (r_count == CCW'(CACHE_DEPTH));
    assign list_has   = (r_head < HW'(MAX_BLOCKS));
    assign fresh_has  = (r_fresh < i_pool_n);
    assign cnt_m1     = r_count - CCW'(1);

    always_comb begin
        if (i_item.operation == OP_ALLOC) begin
            if (cache_has)      src = SRC_CACHE;
            else if (list_has)  src = SRC_LIST;
            else if (fresh_has) src = SRC_FRESH;
            else                src = SRC_NONE;
        end else begin
            if (idx_bad)          src = SRC_BAD;
            else if (!cache_full) src = SRC_PUSH_CACHE;
            else                  src = SRC_PUSH_LIST;
        end
    end

    assign o_cache_re    = accept && (src == SRC_CACHE);
    assign o_cache_raddr = cnt_m1[CAW-1:0];
    assign o_cache_we    = accept && (src == SRC_PUSH_CACHE);
    assign o_cache_waddr = r_count[CAW-1:0];
    assign o_cache_wdata = idx_i;
    assign o_link_re     = accept && (src == SRC_LIST);
    assign o_link_raddr  = r_head[IW-1:0];
    assign o_link_we     = accept && (src == SRC_PUSH_LIST);
    assign o_link_waddr  = idx_i;
    assign o_link_wdata  = r_head;

    always_comb begin
        n_src   = r_src;
        n_grant = r_grant;
        n_head  = r_head;
        n_fresh = r_fresh;
        n_count = r_count;
        if (accept) begin
            n_src = src;
            case (src)
                SRC_CACHE:      n_count = cnt_m1;
                SRC_LIST:       n_grant = r_head[IW-1:0];
                SRC_FRESH: begin
                    n_grant = r_fresh[IW-1:0];
                    n_fresh = r_fresh + HW'(1);
                end
                SRC_PUSH_CACHE: n_count = r_count + CCW'(1);
                SRC_PUSH_LIST:  n_head  = HW'(idx_i);
                default:        n_src   = src;
            endcase
        end
        if (lookup && (r_src == SRC_LIST)) begin
            n_head = i_link_rdata;
        end
    end

    assign lk_grant = (r_src == SRC_CACHE) ? i_cache_rdata : r_grant;

    always_comb begin
        n_result = '0;
        case (r_src)
            SRC_CACHE: begin
                n_result.granted_index = INDEX_W'({{INDEX_W{1'b0}}, lk_grant});
                n_result.from_cache    = 1'b1;
            end
            SRC_LIST, SRC_FRESH: begin
                n_result.granted_index = INDEX_W'({{INDEX_W{1'b0}}, lk_grant});
            end
            SRC_NONE:       n_result.status     = STATUS_EMPTY;
            SRC_PUSH_CACHE: n_result.from_cache = 1'b1;
            SRC_PUSH_LIST:  n_result.status     = STATUS_OK;
            SRC_BAD:        n_result.status     = STATUS_BAD_INDEX;
            default:        n_result.status     = STATUS_OK;
        endcase
        if (r_src == SRC_CACHE || r_src == SRC_LIST || r_src == SRC_FRESH) begin
            n_result.byte_offset = OFFSET_W'({{OFFSET_W{1'b0}}, prod});
        end
    end

    assign prod = PW'(lk_grant) * PW'(i_bsize);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_head  <= HW'(MAX_BLOCKS);
            r_fresh <= '0;
            r_count <= '0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_head  <= n_head;
            r_fresh <= n_fresh;
            r_count <= n_count;
            r_done  <= lookup;
        end
    end

    always_ff @(posedge i_clk) begin
        r_src   <= n_src;
        r_grant <= n_grant;
        if (lookup) begin
            r_result <= n_result;
        end
    end

    assign o_done   = r_done;
    assign o_result = r_result;

endmodule

[rtl/fixed_block_pool_allocator.sv]
// Top level of the fixed-size block pool allocator.
// An item is taken when start is high and busy is low. Its result shows on
// o_result for one cycle, marked by o_done, and it cannot be held off.
// Busy stays high while an item is in lookup, so a new item is not taken
// until the one before is through. The cache stack or link memory read is
// issued at the accepting edge as a synchronous registered read. In the
// following cycle the grant and its byte offset are formed from the read
// data and registered. The result is shown in the cycle after that, and a
// new item may be started in that cycle. There is no clearing pass after reset.
// Configuration writes take effect at the next clock edge.
module fixed_block_pool_allocator #(
    parameter int MAX_BLOCKS  = fbpa_pkg::MAX_BLOCKS_DEF,
    parameter int CACHE_DEPTH = fbpa_pkg::CACHE_DEPTH_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           start,
    output logic                           busy,
    input  fbpa_pkg::t_item                i_item,
    output logic                           o_done,
    output fbpa_pkg::t_result              o_result,
    input  logic                           i_cfg_we,
    input  fbpa_pkg::t_cfg_index           i_cfg_index,
    input  logic [fbpa_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    import fbpa_pkg::*;

    localparam int HW  = $clog2(MAX_BLOCKS + 1);
    localparam int IW  = $clog2(MAX_BLOCKS);
    localparam int CAW = (CACHE_DEPTH > 1) ? $clog2(CACHE_DEPTH) : 1;
    localparam int CW  = BLOCKS_W + HW;
    localparam int POOL_RST = (BLOCKS_RST > MAX_BLOCKS) ? MAX_BLOCKS : BLOCKS_RST;

    logic [HW-1:0]      r_pool_n, n_pool_n;
    logic [BYTES_W-1:0] r_bsize, n_bsize;
    logic [CW-1:0]      blocks_wide, pool_clamp;
    logic [BYTES_W-1:0] bytes_in;

    logic           cache_we, cache_re, link_we, link_re;
    logic [CAW-1:0] cache_waddr, cache_raddr;
    logic [IW-1:0]  cache_wdata, cache_rdata;
    logic [IW-1:0]  link_waddr, link_raddr;
    logic [HW-1:0]  link_wdata, link_rdata;

    assign blocks_wide = {{HW{1'b0}}, i_cfg_data[BLOCKS_W-1:0]};
    assign pool_clamp  = (blocks_wide > CW'(MAX_BLOCKS)) ? CW'(MAX_BLOCKS) : blocks_wide;
    assign bytes_in    = i_cfg_data[BYTES_W-1:0];

    always_comb begin
        n_pool_n = r_pool_n;
        n_bsize  = r_bsize;
        if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_BLOCKS_IN_USE: n_pool_n = pool_clamp[HW-1:0];
                CFG_BLOCK_BYTES: begin
                    if (bytes_in < MIN_BLOCK_BYTES)      n_bsize = MIN_BLOCK_BYTES;
                    else if (bytes_in > MAX_BLOCK_BYTES) n_bsize = MAX_BLOCK_BYTES;
                    else                                 n_bsize = bytes_in;
                end
                default: n_pool_n = r_pool_n;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pool_n <= HW'(POOL_RST);
            r_bsize  <= MIN_BLOCK_BYTES;
        end else begin
            r_pool_n <= n_pool_n;
            r_bsize  <= n_bsize;
        end
    end

    fbpa_ctrl #(
        .MAX_BLOCKS  (MAX_BLOCKS),
        .CACHE_DEPTH (CACHE_DEPTH)
    ) u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_item        (i_item),
        .i_pool_n      (r_pool_n),
        .i_bsize       (r_bsize),
        .o_done        (o_done),
        .o_result      (o_result),
        .o_cache_we    (cache_we),
        .o_cache_waddr (cache_waddr),
        .o_cache_wdata (cache_wdata),
        .o_cache_re    (cache_re),
        .o_cache_raddr (cache_raddr),
        .i_cache_rdata (cache_rdata),
        .o_link_we     (link_we),
        .o_link_waddr  (link_waddr),
        .o_link_wdata  (link_wdata),
        .o_link_re     (link_re),
        .o_link_raddr  (link_raddr),
        .i_link_rdata  (link_rdata)
    );

    fbpa_ram #(
        .WIDTH (IW),
        .DEPTH (CACHE_DEPTH)
    ) u_cache_ram (
        .i_clk   (i_clk),
        .i_we    (cache_we),
        .i_waddr (cache_waddr),
        .i_wdata (cache_wdata),
        .i_re    (cache_re),
        .i_raddr (cache_raddr),
        .o_rdata (cache_rdata)
    );

    fbpa_ram #(
        .WIDTH (HW),
        .DEPTH (MAX_BLOCKS)
    ) u_link_ram (
        .i_clk   (i_clk),
        .i_we    (link_we),
        .i_waddr (link_waddr),
        .i_wdata (link_wdata),
        .i_re    (link_re),
        .i_raddr (link_raddr),
        .o_rdata (link_rdata)
    );

endmodule

[rtl/fbpa_checker.sv]
// Port-level assertions for the block pool allocator, with bind.
`include "fixed_block_pool_allocator_defines.svh"

module fbpa_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           start,
    input logic                           busy,
    input logic                           o_done,
    input fbpa_pkg::t_result              o_result
);

    import fbpa_pkg::*;

    logic accept, fail_clean, status_legal;
    assign accept = start && !busy;
    assign fail_clean = (o_result.granted_index == '0) && (o_result.byte_offset == '0)
                        && !o_result.from_cache;
    assign status_legal = (o_result.status == STATUS_OK) || (o_result.status == STATUS_EMPTY)
                          || (o_result.status == STATUS_BAD_INDEX);

    `FBPA_ASSERT_NEXT(a_busy_after_accept, accept, busy, "busy not raised after item")
    `FBPA_ASSERT_TWO(a_result_latency, accept, o_done, "result missing after item")
    `FBPA_ASSERT_NOW(a_done_idle, o_done, !busy, "result shown while busy")
    `FBPA_ASSERT_NOW(a_fail_clean, o_done && (o_result.status != STATUS_OK), fail_clean, "grant data")
    `FBPA_ASSERT_NOW(a_status_code, o_done, status_legal, "undefined status code")

endmodule

bind fixed_block_pool_allocator fbpa_checker u_fbpa_checker (.*);

[bench/testbench.sv]
// Self-checking testbench for the fixed-size block pool allocator.
module testbench;
    import fbpa_pkg::*;

    localparam int CYCLE_LIMIT = 100000;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  start;
    logic                  busy;
    t_item                 i_item;
    logic                  o_done;
    t_result               o_result;
    logic                  i_cfg_we;
    t_cfg_index            i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    fixed_block_pool_allocator DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_item      (i_item),
        .o_done      (o_done),
        .o_result    (o_result),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // Pool state as the block should hold it; links keep the 13-bit empty marker.
    logic [BLOCKS_W-1:0] link_mem [MAX_BLOCKS_DEF];
    logic [INDEX_W-1:0]  cache_stack_m [CACHE_DEPTH_DEF];
    int unsigned         cache_fill = 0;
    logic [BLOCKS_W-1:0] list_head = BLOCKS_W'(MAX_BLOCKS_DEF);
    logic [BLOCKS_W-1:0] fresh_next = '0;
    logic [BLOCKS_W-1:0] pool_blocks = BLOCKS_W'(BLOCKS_RST);
    logic [BYTES_W-1:0]  pool_bytes = MIN_BLOCK_BYTES;

    t_result            pending_results [$];
    logic [INDEX_W-1:0] held_blocks [$];
    t_result            want;
    int                 idle_pct = 0;
    int                 errors = 0;
    int                 items_sent = 0;
    int                 results_seen = 0;
    int                 n_cache_grants = 0;
    int                 n_list_grants = 0;
    int                 n_fresh_grants = 0;
    int                 n_empty = 0;
    int                 n_cache_frees = 0;
    int                 n_list_frees = 0;
    int                 n_bad_frees = 0;
    int unsigned        cycle_count = 0;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, pending_results.size());
            $display("RESULT: ERROR");
            $finish;
        end
    end

    function automatic logic [BLOCKS_W-1:0] pool_limit();
        return (pool_blocks > BLOCKS_W'(MAX_BLOCKS_DEF)) ? BLOCKS_W'(MAX_BLOCKS_DEF)
                                                       : pool_blocks;
    endfunction

    function automatic t_result pool_predict(t_item it);
        t_result             r;
        logic [BLOCKS_W-1:0] n;
        logic [BYTES_W-1:0]  sz;
        logic [INDEX_W-1:0]  g;
        logic [31:0]         prod;
        r = '0;
        g = '0;
        n = pool_limit();
        if (pool_bytes < MIN_BLOCK_BYTES)
            sz = MIN_BLOCK_BYTES;
        else if (pool_bytes > MAX_BLOCK_BYTES)
            sz = MAX_BLOCK_BYTES;
        else
            sz = pool_bytes;
        if (it.operation == OP_ALLOC) begin
            r.status = STATUS_OK;
            if (cache_fill != 0) begin
                cache_fill--;
                g = cache_stack_m[cache_fill];
                r.from_cache = 1'b1;
                n_cache_grants++;
            end else if (list_head < BLOCKS_W'(MAX_BLOCKS_DEF)) begin
                g = list_head[INDEX_W-1:0];
                list_head = link_mem[g];
                n_list_grants++;
            end else if (fresh_next < n) begin
                g = fresh_next[INDEX_W-1:0];
                fresh_next++;
                n_fresh_grants++;
            end else begin
                r.status = STATUS_EMPTY;
                n_empty++;
            end
            if (r.status == STATUS_OK) begin
                prod = 32'(g) * 32'(sz);
                r.granted_index = g;
                r.byte_offset = prod[OFFSET_W-1:0];
            end
        end else if ({1'b0, it.block_index} >= n) begin
            r.status = STATUS_BAD_INDEX;
            n_bad_frees++;
        end else if (cache_fill < CACHE_DEPTH_DEF) begin
            r.status = STATUS_OK;
            cache_stack_m[cache_fill] = it.block_index;
            cache_fill++;
            r.from_cache = 1'b1;
            n_cache_frees++;
        end else begin
            r.status = STATUS_OK;
            link_mem[it.block_index] = list_head;
            list_head = {1'b0, it.block_index};
            n_list_frees++;
        end
        return r;
    endfunction

    always @(negedge i_clk) begin
        if (i_rst_n && o_done) begin
            results_seen++;
            if (pending_results.size() == 0) begin
                $error("result with no item outstanding");
                errors++;
            end else begin
                want = pending_results.pop_front();
                if (o_result.status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, o_result.status);
                    errors++;
                end
                if (o_result.granted_index !== want.granted_index) begin
                    $error("granted_index: expected %0d, got %0d",
                           want.granted_index, o_result.granted_index);
                    errors++;
                end
                if (o_result.byte_offset !== want.byte_offset) begin
                    $error("byte_offset: expected %0d, got %0d",
                           want.byte_offset, o_result.byte_offset);
                    errors++;
                end
                if (o_result.from_cache !== want.from_cache) begin
                    $error("from_cache: expected %0d, got %0d",
                           want.from_cache, o_result.from_cache);
                    errors++;
                end
            end
        end
    end

    // Called right after a rising edge; returns right after the accepting edge, or after an idle gap if idle_pct asks.
    task automatic send_item(t_op op, logic [INDEX_W-1:0] idx, output t_result r);
        t_item it;
        it.operation = op;
        it.block_index = idx;
        start <= 1'b1;
        i_item <= it;
        do @(negedge i_clk); while (busy);
        @(posedge i_clk);
        r = pool_predict(it);
        pending_results.insert(pending_results.size(), r);
        items_sent++;
        if (idle_pct != 0 && $urandom_range(99, 0) < idle_pct) begin
            start <= 1'b0;
            repeat ($urandom_range(6, 1)) @(posedge i_clk);
        end
    endtask

    task automatic alloc_item();
        t_result r;
        send_item(OP_ALLOC, INDEX_W'($urandom_range(4095, 0)), r);
    endtask

    task automatic free_item(logic [INDEX_W-1:0] idx);
        t_result r;
        send_item(OP_FREE, idx, r);
    endtask

    task automatic wait_drained();
        start <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (3) @(posedge i_clk);
    endtask

    task automatic write_config(logic [CFG_DATA_W-1:0] blocks_word,
                                logic [CFG_DATA_W-1:0] bytes_word);
        i_cfg_we <= 1'b1;
        i_cfg_index <= CFG_BLOCKS_IN_USE;
        i_cfg_data <= blocks_word;
        @(posedge i_clk);
        i_cfg_index <= CFG_BLOCK_BYTES;
        i_cfg_data <= bytes_word;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        pool_blocks = blocks_word[BLOCKS_W-1:0];
        pool_bytes = bytes_word[BYTES_W-1:0];
        @(posedge i_clk);
    endtask

    // Reset registers: fresh grants, cache reuse, top index, a double free.
    task automatic test_reset_defaults();
        idle_pct = 0;
        alloc_item();
        alloc_item();
        alloc_item();
        free_item(12'd1);
        alloc_item();
        free_item(12'd4095);
        alloc_item();
        free_item(12'd2);
        free_item(12'd2);
        alloc_item();
        alloc_item();
    endtask

    // One-block pool, empty pool, clamped size, block size below and above range.
    task automatic test_config_extremes();
        wait_drained();
        write_config(17'd1, 17'd0);
        alloc_item();
        free_item(12'd1);
        free_item(12'd0);
        alloc_item();
        wait_drained();
        write_config(17'd0, 17'h1FFFF);
        alloc_item();
        free_item(12'd0);
        wait_drained();
        write_config(17'h01FFF, 17'h10000);
        free_item(12'd4095);
        alloc_item();
        free_item(12'd0);
        alloc_item();
    endtask

    // Bursts of allocates and frees of held blocks, so the cache overflows into
    // the list and small pools run dry; a few frees use out-of-range indexes.
    task automatic test_mixed_traffic(int pct, int count,
                                      logic [CFG_DATA_W-1:0] blocks_word,
                                      logic [CFG_DATA_W-1:0] bytes_word);
        t_result             r;
        int                  done_items;
        int                  burst;
        int                  roll;
        int                  pick;
        bit                  fill;
        bit                  want_free;
        logic [BLOCKS_W-1:0] n;
        logic [INDEX_W-1:0]  idx;
        wait_drained();
        write_config(blocks_word, bytes_word);
        idle_pct = pct;
        n = pool_limit();
        done_items = 0;
        while (done_items < count) begin
            burst = $urandom_range(220, 20);
            fill = 1'($urandom_range(1, 0));
            while (burst > 0 && done_items < count) begin
                roll = $urandom_range(99, 0);
                want_free = fill ? (roll >= 88) : (roll >= 15);
                if (roll < 5 && n < BLOCKS_W'(MAX_BLOCKS_DEF)) begin
                    send_item(OP_FREE, INDEX_W'($urandom_range(4095, 32'(n))), r);
                end else if (want_free && held_blocks.size() != 0) begin
                    pick = $urandom_range(held_blocks.size() - 1, 0);
                    idx = held_blocks[pick];
                    held_blocks.delete(pick);
                    send_item(OP_FREE, idx, r);
                end else begin
                    send_item(OP_ALLOC, INDEX_W'($urandom_range(4095, 0)), r);
                    if (r.status == STATUS_OK)
                        held_blocks.insert(held_blocks.size(), r.granted_index);
                end
                burst--;
                done_items++;
            end
        end
    endtask

    initial begin
        start <= 1'b0;
        i_item <= '0;
        i_cfg_we <= 1'b0;
        i_cfg_index <= CFG_BLOCKS_IN_USE;
        i_cfg_data <= '0;
        i_rst_n <= 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_defaults();
        test_config_extremes();
        test_mixed_traffic(0, 300, 17'd4096, 17'd64);
        test_mixed_traffic(67, 300, 17'd200,
                           CFG_DATA_W'(17'd1000 + $urandom_range(64000, 0)));
        test_mixed_traffic(0, 280, 17'h1E096, 17'd20);
        test_mixed_traffic(33, 270, 17'h01000, 17'h10000);

        wait_drained();
        repeat (10) @(posedge i_clk);
        $display("Sent %0d items, checked %0d results; grants: %0d cache, %0d list, %0d fresh",
                 items_sent, results_seen, n_cache_grants, n_list_grants, n_fresh_grants);
        $display("Pool empty %0d times; frees: %0d to cache, %0d to list, %0d rejected",
                 n_empty, n_cache_frees, n_list_frees, n_bad_frees);
        if (errors == 0 && pending_results.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end
endmodule

[filelist.f]
+incdir+rtl
rtl/fbpa_pkg.sv
rtl/fbpa_ram.sv
rtl/fbpa_ctrl.sv
rtl/fixed_block_pool_allocator.sv
rtl/fbpa_checker.sv
bench/testbench.sv
